/* rtl/core/aevc_pkg.sv */
// Shared constants and types for the ADSR envelope VCA core.
// No dependencies; imported by every module under rtl/core.

package aevc_pkg;

  // Default parameter values for the top level
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COUNT_WIDTH  = 20;

  // Fixed field widths
  localparam int MS_W       = 13;   // stage times in ms
  localparam int RATE_W     = 18;   // sample rate in Hz
  localparam int LVL_W      = 17;   // Q1.16 level, 65536 = full scale
  localparam int LVL_FRAC   = 16;   // fraction bits of a level
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Level constants
  localparam logic [LVL_W-1:0] LVL_FULL  = 17'd65536;
  localparam logic [LVL_W-1:0] REL_FLOOR = 17'd7;

  // Stage time limits (ms)
  localparam logic [MS_W-1:0] MS_MIN = 13'd1;
  localparam logic [MS_W-1:0] MS_MAX = 13'd5000;

  // Length = ceil(ms * rate / 1000): numerator fits 31 bits, quotient 21 bits
  localparam int LEN_NUM_W   = MS_W + RATE_W;
  localparam int LEN_QW      = 21;
  localparam int LEN_DIVISOR = 1000;
  localparam int LEN_ROUND   = 999;

  // Quotient bits of a level division (quotient never exceeds 65536)
  localparam int LVL_QB = LVL_W;

  // Step counter width of the serial divider
  localparam int CNT_W = $clog2(LEN_QW + 1);

  // Register reset values
  localparam logic [MS_W-1:0]   RST_ATTACK_MS  = 13'd10;
  localparam logic [MS_W-1:0]   RST_DECAY_MS   = 13'd120;
  localparam logic [LVL_W-1:0]  RST_SUSTAIN    = 17'd45875;
  localparam logic [MS_W-1:0]   RST_RELEASE_MS = 13'd200;
  localparam logic [RATE_W-1:0] RST_RATE_HZ    = 18'd48000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 3'd4;

  // Envelope stage
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

endpackage

/* rtl/core/aevc_serial_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on aevc_pkg for the default multiplier width.

module aevc_serial_mul import aevc_pkg::*; #(
  parameter int AW = 20,
  parameter int BW = LVL_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW+BW-1:0] prod
);

  localparam int NW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] p_r;
  logic [NW-1:0]    cnt_r;
  logic             done_r;
  logic [AW:0]      sum;

  // Add the multiplicand into the upper half when the current bit is set
  assign sum = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= NW'(BW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{AW{1'b0}}, b};
    end else if (cnt_r != '0) begin
      p_r <= {sum, p_r[BW-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

/* rtl/core/aevc_serial_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on aevc_pkg; the caller supplies the partial remainder that precedes the quotient bits.

module aevc_serial_div import aevc_pkg::*; #(
  parameter int DW = 20,
  parameter int QW = LEN_QW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               rem0,
  input  logic [QW-1:0]               lo,
  input  logic [DW-1:0]               den,
  input  logic [$clog2(QW+1)-1:0]     steps,
  output logic                        done,
  output logic [QW-1:0]               quot
);

  localparam int NW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] cnt_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, q_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      q_r   <= lo;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

  // The partial remainder must stay below the divisor for the quotient to fit
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

endmodule

/* rtl/core/adsr_envelope_vca_core.sv */
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_req_type, in_gate_on, in_sample_in
// out       out_valid / out_ready     out_sample_out, out_env_level
// cfg       cfg_we (no wait)          cfg_index, cfg_wdata
//
// One request at a time. A gate event is taken in the idle state and returns nothing.
// A sample in attack, decay or release runs serial steps in turn: a 17-bit
// multiply and a 21-bit divide for the stage length, a counter step, then the
// level (17-bit multiply and 17-bit divide in decay or release, a 17-bit divide
// alone in attack) and last a 17-bit multiply by the level; the result is then
// loaded into the output register. A sample that ends its stage skips the level
// math. In sustain, idle or before the first gate only the last multiply runs.
// Reset is synchronous and active low.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only a second finished result stalls on out_ready.
// Depends on aevc_pkg, aevc_serial_mul and aevc_serial_div.

module adsr_envelope_vca_core import aevc_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic                           in_gate_on,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic [LVL_W-1:0]               out_env_level,
  // configuration
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CW      = COUNT_WIDTH;
  localparam int AW0     = (CW > RATE_W) ? CW : RATE_W;
  localparam int MUL_AW  = (SW > AW0) ? SW : AW0;
  localparam int MUL_PW  = MUL_AW + LVL_W;
  localparam int LW      = (CW > LEN_QW) ? CW : LEN_QW;
  localparam int DIV_QW  = LEN_QW;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LEN_MUL = 8'b0000_0010,
    S_LEN_DIV = 8'b0000_0100,
    S_STEP    = 8'b0000_1000,
    S_LVL_MUL = 8'b0001_0000,
    S_LVL_DIV = 8'b0010_0000,
    S_OUT_MUL = 8'b0100_0000,
    S_WB      = 8'b1000_0000
  } state_t;

  // Configuration registers
  logic [MS_W-1:0]   attack_ms_r, decay_ms_r, release_ms_r;
  logic [LVL_W-1:0]  sustain_r;
  logic [RATE_W-1:0] rate_r;

  // Control and envelope state
  state_t            state_r, state_nxt;
  stage_t            stage_r, stage_nxt;
  logic [CW-1:0]     samples_r, samples_nxt;
  logic [LVL_W-1:0]  env_r, env_nxt;
  logic [LVL_W-1:0]  rel_r, rel_nxt;
  logic              gate_seen_r, gate_seen_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic [SW-1:0]     mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [SW-1:0]     out_sample_r, out_sample_nxt;
  logic [LVL_W-1:0]  out_level_r, out_level_nxt;

  // Arithmetic unit hookup
  logic              mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [LVL_W-1:0]  mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic              div_start, div_done;
  logic [CW-1:0]     div_rem0, div_den;
  logic [DIV_QW-1:0] div_lo, div_q;
  logic [CNT_W-1:0]  div_steps;

  // Derived values
  logic [RATE_W-1:0]    rate_eff;
  logic [LVL_W-1:0]     sus_c;
  logic [MS_W-1:0]      ms_raw, ms_c;
  logic [LEN_NUM_W-1:0] len_num;
  logic [LW-1:0]        len_qx;
  logic [CW-1:0]        len_cap;
  logic [CW:0]          n_full;
  logic                 stage_end;
  logic [CW-1:0]        n_sat;
  logic [LVL_W-1:0]     lvl_q, lvl_div;
  logic [SW-1:0]        in_raw, in_mag, out_mag, out_res;
  logic                 in_neg;
  logic                 go_out;
  logic [LVL_W-1:0]     out_lvl;

  assign in_ready = (state_r == S_IDLE);

  // Register clamps
  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign sus_c    = (sustain_r > LVL_FULL) ? LVL_FULL : sustain_r;

  always_comb begin
    unique case (stage_r)
      ST_ATTACK: ms_raw = attack_ms_r;
      ST_DECAY:  ms_raw = decay_ms_r;
      default:   ms_raw = release_ms_r;
    endcase
  end

  assign ms_c = (ms_raw < MS_MIN) ? MS_MIN : ((ms_raw > MS_MAX) ? MS_MAX : ms_raw);

  // Stage length: round up, then saturate at the counter range
  assign len_num = mul_p[LEN_NUM_W-1:0] + LEN_NUM_W'(LEN_ROUND);
  assign len_qx  = LW'(div_q[LEN_QW-1:0]);
  assign len_cap = (len_qx > LW'({CW{1'b1}})) ? {CW{1'b1}} : len_qx[CW-1:0];

  // Advanced counter, saturated at the stage length
  assign n_full    = {1'b0, samples_r} + (CW+1)'(1);
  assign stage_end = (n_full >= {1'b0, len_r});
  assign n_sat     = stage_end ? len_r : n_full[CW-1:0];

  // Level from the divider; decay counts down from full scale
  assign lvl_q   = div_q[LVL_QB-1:0];
  assign lvl_div = (stage_r == ST_DECAY) ? (LVL_FULL - lvl_q) : lvl_q;

  // Sign-magnitude handling of the sample; magnitude floor gives truncation toward zero
  assign in_raw  = in_sample_in;
  assign in_neg  = in_raw[SW-1];
  assign in_mag  = in_neg ? (~in_raw + 1'b1) : in_raw;
  assign out_mag = mul_p[LVL_FRAC +: SW];
  assign out_res = neg_r ? (~out_mag + 1'b1) : out_mag;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    stage_nxt      = stage_r;
    samples_nxt    = samples_r;
    env_nxt        = env_r;
    rel_nxt        = rel_r;
    gate_seen_nxt  = gate_seen_r;
    out_valid_nxt  = out_valid_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    len_nxt        = len_r;
    level_nxt      = level_r;
    out_sample_nxt = out_sample_r;
    out_level_nxt  = out_level_r;
    mul_start      = 1'b0;
    mul_a          = MUL_AW'(mag_r);
    mul_b          = '0;
    div_start      = 1'b0;
    div_rem0       = '0;
    div_lo         = '0;
    div_den        = len_r;
    div_steps      = CNT_W'(LVL_QB);
    go_out         = 1'b0;
    out_lvl        = level_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type) begin
            // gate event: restart the counter in attack or release
            gate_seen_nxt = 1'b1;
            samples_nxt   = '0;
            if (in_gate_on) begin
              stage_nxt = ST_ATTACK;
            end else begin
              stage_nxt = ST_RELEASE;
              rel_nxt   = (env_r > REL_FLOOR) ? env_r : REL_FLOOR;
            end
          end else begin
            mag_nxt = in_mag;
            neg_nxt = in_neg;
            if (!gate_seen_r) begin
              go_out  = 1'b1;
              out_lvl = LVL_FULL;
            end else begin
              unique case (stage_r)
                ST_ATTACK, ST_DECAY, ST_RELEASE: begin
                  mul_start = 1'b1;
                  mul_a     = MUL_AW'(rate_eff);
                  mul_b     = LVL_W'(ms_c);
                  state_nxt = S_LEN_MUL;
                end
                ST_SUSTAIN: begin
                  env_nxt = sus_c;
                  go_out  = 1'b1;
                  out_lvl = sus_c;
                end
                default: begin
                  env_nxt = '0;
                  go_out  = 1'b1;
                  out_lvl = '0;
                end
              endcase
            end
          end
        end
      end

      // ms * rate done: divide by 1000
      S_LEN_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_rem0  = CW'(len_num[LEN_NUM_W-1:LEN_QW]);
          div_lo    = len_num[LEN_QW-1:0];
          div_den   = CW'(LEN_DIVISOR);
          div_steps = CNT_W'(LEN_QW);
          state_nxt = S_LEN_DIV;
        end
      end

      S_LEN_DIV: begin
        if (div_done) begin
          len_nxt   = len_cap;
          state_nxt = S_STEP;
        end
      end

      // Advance the counter; end the stage or start the level computation
      S_STEP: begin
        samples_nxt = n_sat;
        unique case (stage_r)
          ST_ATTACK: begin
            if (stage_end) begin
              stage_nxt   = ST_DECAY;
              samples_nxt = '0;
              env_nxt     = LVL_FULL;
              go_out      = 1'b1;
              out_lvl     = LVL_FULL;
            end else begin
              // n * 65536 / L
              div_start = 1'b1;
              div_rem0  = {1'b0, n_sat[CW-1:1]};
              div_lo    = {n_sat[0], {(DIV_QW-1){1'b0}}};
              state_nxt = S_LVL_DIV;
            end
          end
          ST_DECAY: begin
            if (stage_end) begin
              stage_nxt = ST_SUSTAIN;
              env_nxt   = sus_c;
              go_out    = 1'b1;
              out_lvl   = sus_c;
            end else begin
              mul_start = 1'b1;
              mul_a     = MUL_AW'(n_sat);
              mul_b     = LVL_FULL - sus_c;
              state_nxt = S_LVL_MUL;
            end
          end
          ST_RELEASE: begin
            if (stage_end) begin
              stage_nxt = ST_IDLE;
              env_nxt   = '0;
              go_out    = 1'b1;
              out_lvl   = '0;
            end else begin
              mul_start = 1'b1;
              mul_a     = MUL_AW'(len_r - n_sat);
              mul_b     = rel_r;
              state_nxt = S_LVL_MUL;
            end
          end
          default: begin
            go_out  = 1'b1;
            out_lvl = env_r;
          end
        endcase
      end

      // Product over L
      S_LVL_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_rem0  = mul_p[LVL_QB +: CW];
          div_lo    = {mul_p[LVL_QB-1:0], {(DIV_QW-LVL_QB){1'b0}}};
          state_nxt = S_LVL_DIV;
        end
      end

      S_LVL_DIV: begin
        if (div_done) begin
          env_nxt = lvl_div;
          go_out  = 1'b1;
          out_lvl = lvl_div;
        end
      end

      S_OUT_MUL: begin
        if (mul_done) begin
          state_nxt = S_WB;
        end
      end

      // Hand the result to the output register once it is free
      S_WB: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = out_res;
          out_level_nxt  = level_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Scale the sample by the chosen level
    if (go_out) begin
      mul_start = 1'b1;
      mul_a     = MUL_AW'(mag_nxt);
      mul_b     = out_lvl;
      level_nxt = out_lvl;
      state_nxt = S_OUT_MUL;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= ST_IDLE;
      samples_r   <= '0;
      env_r       <= '0;
      rel_r       <= '0;
      gate_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      samples_r   <= samples_nxt;
      env_r       <= env_nxt;
      rel_r       <= rel_nxt;
      gate_seen_r <= gate_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    len_r        <= len_nxt;
    level_r      <= level_nxt;
    out_sample_r <= out_sample_nxt;
    out_level_r  <= out_level_nxt;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_ms_r  <= RST_ATTACK_MS;
      decay_ms_r   <= RST_DECAY_MS;
      sustain_r    <= RST_SUSTAIN;
      release_ms_r <= RST_RELEASE_MS;
      rate_r       <= RST_RATE_HZ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_ms_r  <= cfg_wdata[MS_W-1:0];
        CFG_DECAY:   decay_ms_r   <= cfg_wdata[MS_W-1:0];
        CFG_SUSTAIN: sustain_r    <= cfg_wdata[LVL_W-1:0];
        CFG_RELEASE: release_ms_r <= cfg_wdata[MS_W-1:0];
        CFG_RATE:    rate_r       <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  aevc_serial_mul #(
    .AW (MUL_AW),
    .BW (LVL_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  aevc_serial_div #(
    .DW (CW),
    .QW (DIV_QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .rem0  (div_rem0),
    .lo    (div_lo),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quot  (div_q)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_env_level  = out_level_r;

  // A result appears only out of the write-back state
  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result raised outside write-back");

  // While a level is computed the counter is strictly inside the stage
  a_count_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LVL_MUL || state_r == S_LVL_DIV) |-> (samples_r < len_r))
    else $error("stage counter reached length during level computation");

  // Release always starts from at least the floor level
  a_release_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_RELEASE) |-> (rel_r >= REL_FLOOR))
    else $error("release start below floor");

endmodule
